// File: src/trilerp_pkg.sv
// Shared types, constants and the blend schedule of the trilinear interpolator.
// Used by trilerp_ctrl, trilerp_dp and trilinear_interpolator_core; no dependencies.
package trilerp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Datapath widths that follow from the value format
  localparam int DIFF_W  = VALUE_BITS + 1;          // difference of two values
  localparam int NUM_W   = DIFF_W + FRAC_BITS;      // shifted numerator, fraction width
  localparam int T_LO_W  = (NUM_W + 1) / 2;         // low slice of a fraction
  localparam int T_HI_W  = NUM_W - T_LO_W;          // high slice of a fraction
  localparam int MUL_W   = DIFF_W + T_LO_W;         // one partial product
  localparam int PROD_W  = DIFF_W + NUM_W;          // full blend product
  localparam int CNT_W   = $clog2(NUM_W);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] DIMS_2D    = 2'd2;
  localparam logic [1:0] DIMS_RESET = 2'd3;
  localparam logic       CFG_IDX_DIMS = 1'b0;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Blend operand sources: corners 0..7, partial results 0..3
  localparam logic [3:0] SRC_C0 = 4'd0;
  localparam logic [3:0] SRC_C1 = 4'd1;
  localparam logic [3:0] SRC_C2 = 4'd2;
  localparam logic [3:0] SRC_C3 = 4'd3;
  localparam logic [3:0] SRC_C4 = 4'd4;
  localparam logic [3:0] SRC_C5 = 4'd5;
  localparam logic [3:0] SRC_C6 = 4'd6;
  localparam logic [3:0] SRC_C7 = 4'd7;
  localparam logic [3:0] SRC_R0 = 4'd8;
  localparam logic [3:0] SRC_R1 = 4'd9;
  localparam logic [3:0] SRC_R2 = 4'd10;
  localparam logic [3:0] SRC_R3 = 4'd11;

  localparam logic [1:0] DST_R0 = 2'd0;
  localparam logic [1:0] DST_R1 = 2'd1;
  localparam logic [1:0] DST_R2 = 2'd2;
  localparam logic [1:0] DST_R3 = 2'd3;

  typedef struct packed {
    logic                          req_type;
    logic [2:0]                    corner_index;
    logic signed [VALUE_BITS-1:0]  corner_value;
    logic signed [VALUE_BITS-1:0]  x_low;
    logic signed [VALUE_BITS-1:0]  x_high;
    logic signed [VALUE_BITS-1:0]  y_low;
    logic signed [VALUE_BITS-1:0]  y_high;
    logic signed [VALUE_BITS-1:0]  z_low;
    logic signed [VALUE_BITS-1:0]  z_high;
    logic signed [VALUE_BITS-1:0]  x_pos;
    logic signed [VALUE_BITS-1:0]  y_pos;
    logic signed [VALUE_BITS-1:0]  z_pos;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] interp_value;
    logic [1:0]                   status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPTURE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_RDA,
    OP_RDB,
    OP_MLO,
    OP_MHI,
    OP_ACC,
    OP_END,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic [3:0] a_src;
    logic [3:0] b_src;
    logic [1:0] axis;
    logic [1:0] dst;
    logic       last;
  } lerp_sel_t;

  typedef struct packed {
    dp_op_e    op;
    logic [1:0] axis;
    lerp_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic zero_width;
  } stat_t;

  function automatic lerp_sel_t mk_sel(logic [3:0] a, logic [3:0] b, logic [1:0] ax,
                                       logic [1:0] dst, logic last);
    lerp_sel_t s;
    s.a_src = a;
    s.b_src = b;
    s.axis  = ax;
    s.dst   = dst;
    s.last  = last;
    return s;
  endfunction

  // Blend order: x first, then y, then z in 3-D mode
  function automatic lerp_sel_t lerp_sel(logic [2:0] step, logic three);
    lerp_sel_t s;
    if (three) begin
      case (step)
        3'd0:    s = mk_sel(SRC_C0, SRC_C4, AX_X, DST_R0, 1'b0);
        3'd1:    s = mk_sel(SRC_C1, SRC_C5, AX_X, DST_R1, 1'b0);
        3'd2:    s = mk_sel(SRC_C2, SRC_C6, AX_X, DST_R2, 1'b0);
        3'd3:    s = mk_sel(SRC_C3, SRC_C7, AX_X, DST_R3, 1'b0);
        3'd4:    s = mk_sel(SRC_R0, SRC_R2, AX_Y, DST_R0, 1'b0);
        3'd5:    s = mk_sel(SRC_R1, SRC_R3, AX_Y, DST_R1, 1'b0);
        default: s = mk_sel(SRC_R0, SRC_R1, AX_Z, DST_R0, 1'b1);
      endcase
    end else begin
      case (step)
        3'd0:    s = mk_sel(SRC_C0, SRC_C2, AX_X, DST_R0, 1'b0);
        3'd1:    s = mk_sel(SRC_C1, SRC_C3, AX_X, DST_R1, 1'b0);
        default: s = mk_sel(SRC_R0, SRC_R1, AX_Y, DST_R0, 1'b1);
      endcase
    end
    return s;
  endfunction

endpackage

// File: src/trilerp_ctrl.sv
// Sequencer of the trilinear interpolator: handshakes, divider and blend steps.
// Depends on trilerp_pkg; drives trilerp_dp through cmd_t.
module trilerp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                three_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  trilerp_pkg::stat_t  stat_i,
  output trilerp_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_DIV_INIT = 4'd2;
  localparam logic [3:0] S_DIV_STEP = 4'd3;
  localparam logic [3:0] S_DIV_SAVE = 4'd4;
  localparam logic [3:0] S_RDA      = 4'd5;
  localparam logic [3:0] S_RDB      = 4'd6;
  localparam logic [3:0] S_MLO      = 4'd7;
  localparam logic [3:0] S_MHI      = 4'd8;
  localparam logic [3:0] S_ACC      = 4'd9;
  localparam logic [3:0] S_END      = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  localparam logic [trilerp_pkg::CNT_W-1:0] CNT_LAST =
    trilerp_pkg::CNT_W'(trilerp_pkg::NUM_W - 1);

  logic [3:0]                    state_q, state_d;
  logic [1:0]                    axis_q, axis_d;
  logic [trilerp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]                    step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic [1:0]                    last_axis;
  trilerp_pkg::lerp_sel_t        sel;

  assign sel       = trilerp_pkg::lerp_sel(step_q, three_i);
  assign last_axis = three_i ? trilerp_pkg::AX_Z : trilerp_pkg::AX_Y;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    cmd_o.op   = trilerp_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    cmd_o.sel  = sel;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == trilerp_pkg::REQ_QUERY) begin
            cmd_o.op = trilerp_pkg::OP_CAPTURE;
            state_d  = S_CHECK;
          end else begin
            cmd_o.op = trilerp_pkg::OP_LOAD;
          end
        end
      end
      S_CHECK: begin
        if (stat_i.zero_width) begin
          state_d = S_FIN;
        end else begin
          axis_d  = trilerp_pkg::AX_X;
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op = trilerp_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.op = trilerp_pkg::OP_DIV_STEP;
        if (cnt_q == CNT_LAST) begin
          state_d = S_DIV_SAVE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV_SAVE: begin
        cmd_o.op = trilerp_pkg::OP_DIV_SAVE;
        if (axis_q == last_axis) begin
          step_d  = '0;
          state_d = S_RDA;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DIV_INIT;
        end
      end
      S_RDA: begin
        cmd_o.op = trilerp_pkg::OP_RDA;
        state_d  = S_RDB;
      end
      S_RDB: begin
        cmd_o.op = trilerp_pkg::OP_RDB;
        state_d  = S_MLO;
      end
      S_MLO: begin
        cmd_o.op = trilerp_pkg::OP_MLO;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = trilerp_pkg::OP_MHI;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = trilerp_pkg::OP_ACC;
        state_d  = S_END;
      end
      S_END: begin
        cmd_o.op = trilerp_pkg::OP_END;
        if (sel.last) begin
          state_d = S_FIN;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_RDA;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = trilerp_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.op == trilerp_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/trilerp_dp.sv
// Datapath of the trilinear interpolator: corner store, bit-serial divider,
// shared multiplier for the blends and the output register. Depends on trilerp_pkg.
module trilerp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               three_i,
  input  trilerp_pkg::cmd_t  cmd_i,
  input  trilerp_pkg::in_t   in_data_i,
  output trilerp_pkg::stat_t stat_o,
  output trilerp_pkg::out_t  out_data_o
);

  localparam int V  = trilerp_pkg::VALUE_BITS;
  localparam int F  = trilerp_pkg::FRAC_BITS;
  localparam int DW = trilerp_pkg::DIFF_W;
  localparam int NW = trilerp_pkg::NUM_W;
  localparam int TL = trilerp_pkg::T_LO_W;
  localparam int MW = trilerp_pkg::MUL_W;
  localparam int PW = trilerp_pkg::PROD_W;

  localparam logic [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

  logic [V-1:0]  corner_q [8];
  logic [V-1:0]  lo_q [3];
  logic [V-1:0]  hi_q [3];
  logic [V-1:0]  pos_q [3];
  logic          zero_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic          div_neg_q;
  logic [NW-1:0] t_q [3];
  logic          tneg_q [3];
  logic [V-1:0]  a_q;
  logic [DW-1:0] dmag_q;
  logic          lneg_q;
  logic [NW-1:0] tsel_q;
  logic [MW-1:0] plo_q;
  logic [MW-1:0] phi_q;
  logic [PW-1:0] prod_q;
  logic [V-1:0]  r_q [4];
  logic          sat_q;
  trilerp_pkg::out_t out_q;

  logic [V-1:0]  ax_lo, ax_hi, ax_pos;
  logic [DW-1:0] num, den, nmag, dmag;
  logic [DW:0]   rem_sh;
  logic          fits;
  logic [3:0]    rd_src;
  logic [V-1:0]  rd_val;
  logic [DW-1:0] diff;
  logic [NW-1:0] t_sel;
  logic          t_neg;
  logic [TL-1:0] mul_b;
  logic [MW-1:0] mul_p;
  logic [PW-1:0] acc;
  logic          big;
  logic [V-1:0]  pmag;
  logic [V+1:0]  sum;
  logic [V-1:0]  lerp_res;
  logic          lerp_sat;

  // axis operands for the divider
  always_comb begin
    case (cmd_i.axis)
      trilerp_pkg::AX_Y: begin
        ax_lo = lo_q[1]; ax_hi = hi_q[1]; ax_pos = pos_q[1];
      end
      trilerp_pkg::AX_Z: begin
        ax_lo = lo_q[2]; ax_hi = hi_q[2]; ax_pos = pos_q[2];
      end
      default: begin
        ax_lo = lo_q[0]; ax_hi = hi_q[0]; ax_pos = pos_q[0];
      end
    endcase
  end

  assign num  = {ax_pos[V-1], ax_pos} - {ax_lo[V-1], ax_lo};
  assign den  = {ax_hi[V-1], ax_hi} - {ax_lo[V-1], ax_lo};
  assign nmag = num[DW-1] ? (~num + 1'b1) : num;
  assign dmag = den[DW-1] ? (~den + 1'b1) : den;

  // restoring division, one quotient bit per step
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  // one read port on the blend operands
  assign rd_src = (cmd_i.op == trilerp_pkg::OP_RDA) ? cmd_i.sel.a_src : cmd_i.sel.b_src;
  assign rd_val = rd_src[3] ? r_q[rd_src[1:0]] : corner_q[rd_src[2:0]];
  assign diff   = {rd_val[V-1], rd_val} - {a_q[V-1], a_q};

  always_comb begin
    case (cmd_i.sel.axis)
      trilerp_pkg::AX_Y: begin t_sel = t_q[1]; t_neg = tneg_q[1]; end
      trilerp_pkg::AX_Z: begin t_sel = t_q[2]; t_neg = tneg_q[2]; end
      default:           begin t_sel = t_q[0]; t_neg = tneg_q[0]; end
    endcase
  end

  // shared multiplier: low slice of the fraction, then high slice
  assign mul_b = (cmd_i.op == trilerp_pkg::OP_MLO) ? tsel_q[TL-1:0]
                                                   : TL'(tsel_q[NW-1:TL]);
  assign mul_p = MW'(dmag_q) * MW'(mul_b);
  assign acc   = (PW'(phi_q) << TL) + PW'(plo_q);

  // drop the fraction bits, then add to the start value and clamp
  assign big  = |prod_q[PW-1:F+V];
  assign pmag = prod_q[F+V-1:F];
  assign sum  = lneg_q ? ({{2{a_q[V-1]}}, a_q} - {2'b00, pmag})
                       : ({{2{a_q[V-1]}}, a_q} + {2'b00, pmag});

  always_comb begin
    lerp_sat = 1'b0;
    lerp_res = sum[V-1:0];
    if (big) begin
      lerp_sat = 1'b1;
      lerp_res = lneg_q ? VMIN : VMAX;
    end else if (sum[V+1]) begin
      if (!(sum[V] && sum[V-1])) begin
        lerp_sat = 1'b1;
        lerp_res = VMIN;
      end
    end else if (sum[V] || sum[V-1]) begin
      lerp_sat = 1'b1;
      lerp_res = VMAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        corner_q[i] <= '0;
      end
    end else if (cmd_i.op == trilerp_pkg::OP_LOAD) begin
      corner_q[in_data_i.corner_index] <= in_data_i.corner_value;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      trilerp_pkg::OP_CAPTURE: begin
        lo_q[0]  <= in_data_i.x_low;
        hi_q[0]  <= in_data_i.x_high;
        pos_q[0] <= in_data_i.x_pos;
        lo_q[1]  <= in_data_i.y_low;
        hi_q[1]  <= in_data_i.y_high;
        pos_q[1] <= in_data_i.y_pos;
        lo_q[2]  <= in_data_i.z_low;
        hi_q[2]  <= in_data_i.z_high;
        pos_q[2] <= in_data_i.z_pos;
        zero_q   <= (in_data_i.x_low == in_data_i.x_high) ||
                    (in_data_i.y_low == in_data_i.y_high) ||
                    (three_i && (in_data_i.z_low == in_data_i.z_high));
        sat_q    <= 1'b0;
      end
      trilerp_pkg::OP_DIV_INIT: begin
        quo_q     <= {nmag, {F{1'b0}}};
        rem_q     <= '0;
        den_q     <= dmag;
        div_neg_q <= num[DW-1] ^ den[DW-1];
      end
      trilerp_pkg::OP_DIV_STEP: begin
        if (fits) begin
          rem_q <= DW'(rem_sh - {1'b0, den_q});
        end else begin
          rem_q <= rem_sh[DW-1:0];
        end
        quo_q <= {quo_q[NW-2:0], fits};
      end
      trilerp_pkg::OP_DIV_SAVE: begin
        case (cmd_i.axis)
          trilerp_pkg::AX_Y: begin t_q[1] <= quo_q; tneg_q[1] <= div_neg_q; end
          trilerp_pkg::AX_Z: begin t_q[2] <= quo_q; tneg_q[2] <= div_neg_q; end
          default:           begin t_q[0] <= quo_q; tneg_q[0] <= div_neg_q; end
        endcase
      end
      trilerp_pkg::OP_RDA: begin
        a_q <= rd_val;
      end
      trilerp_pkg::OP_RDB: begin
        dmag_q <= diff[DW-1] ? (~diff + 1'b1) : diff;
        lneg_q <= diff[DW-1] ^ t_neg;
        tsel_q <= t_sel;
      end
      trilerp_pkg::OP_MLO: begin
        plo_q <= mul_p;
      end
      trilerp_pkg::OP_MHI: begin
        phi_q <= mul_p;
      end
      trilerp_pkg::OP_ACC: begin
        prod_q <= acc;
      end
      trilerp_pkg::OP_END: begin
        r_q[cmd_i.sel.dst] <= lerp_res;
        sat_q <= sat_q | lerp_sat;
      end
      trilerp_pkg::OP_OUT: begin
        if (zero_q) begin
          out_q.interp_value <= '0;
          out_q.status       <= trilerp_pkg::ST_ZERO;
        end else begin
          out_q.interp_value <= r_q[0];
          out_q.status       <= sat_q ? trilerp_pkg::ST_SAT : trilerp_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.zero_width = zero_q;
  assign out_data_o        = out_q;

endmodule

// File: src/trilinear_interpolator_core.sv
// Top level of the trilinear interpolator: APB configuration register and the
// controller/datapath pair. Depends on trilerp_pkg, trilerp_ctrl and trilerp_dp.
//
// A load item writes one corner sample. A query item works in 3-D or 2-D mode
// at the Q16.16 format; its run time is set by the restoring divider, which
// forms one bit of each 49-bit fraction per cycle, and by the single 33x25
// multiplier, which each blend uses twice. One item is in work at a time; the
// next one is taken while a finished result waits in the output register. An
// axis of zero width skips the division and the blends.
module trilinear_interpolator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trilerp_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trilerp_pkg::out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]         dims_q;
  logic               three;
  trilerp_pkg::cmd_t  cmd;
  trilerp_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= trilerp_pkg::DIMS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == trilerp_pkg::CFG_IDX_DIMS)) begin
      dims_q <= pwdata[1:0];
    end
  end

  assign three  = (dims_q != trilerp_pkg::DIMS_2D);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == trilerp_pkg::CFG_IDX_DIMS) ? {30'd0, dims_q} : 32'd0;

  trilerp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .three_i     (three),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_data_i.req_type),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trilerp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .three_i    (three),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == trilerp_pkg::ST_ZERO)
      |-> (out_data_o.interp_value == '0))
    else $error("zero-width result carries a nonzero value");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == trilerp_pkg::ST_OK ||
                     out_data_o.status == trilerp_pkg::ST_ZERO ||
                     out_data_o.status == trilerp_pkg::ST_SAT))
    else $error("result status out of range");

  a_load_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.req_type == trilerp_pkg::REQ_LOAD
      && !out_valid_o) |=> !out_valid_o)
    else $error("load item produced a result");

  a_busy_after_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.req_type == trilerp_pkg::REQ_QUERY)
      |=> !in_ready_o)
    else $error("query item did not occupy the block");

endmodule

// File: tb/tb_trilinear_interpolator_core.sv
// Self-checking testbench for trilinear_interpolator_core: corner loads and queries
// checked against an in-bench fixed-point interpolation predictor. Needs trilerp_pkg.
`timescale 1ns / 100ps

module tb_trilinear_interpolator_core;

  localparam int N_RANDOM = 1850;
  localparam logic [2:0] ADDR_DIMS = 3'd0;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  trilerp_pkg::in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  trilerp_pkg::out_t out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  trilinear_interpolator_core u_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // Predictor state
  logic signed [63:0] corners [8];
  logic [1:0]         dims_reg;

  trilerp_pkg::in_t  pending_items [$];
  trilerp_pkg::out_t expected_results [$];
  int   n_errors = 0;
  int   idle_gap = 0;
  int   stall_gap = 0;

  localparam logic signed [63:0] VMAX = 64'sd2147483647;
  localparam logic signed [63:0] VMIN = -64'sd2147483648;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Fraction (pos-lo)<<FRAC / (hi-lo), truncated; false on zero width
  function automatic bit axis_frac(logic signed [31:0] lo, logic signed [31:0] hi,
                                   logic signed [31:0] p, output logic signed [127:0] t);
    logic signed [127:0] num, den;
    num = (128'(p) - 128'(lo)) <<< trilerp_pkg::FRAC_BITS;
    den = 128'(hi) - 128'(lo);
    t = '0;
    if (den == 0) return 0;
    t = num / den;
    return 1;
  endfunction

  function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                               logic signed [127:0] t, inout bit sat);
    logic signed [127:0] prod, r;
    prod = (128'(b) - 128'(a)) * t;
    prod = prod / (128'sd1 <<< trilerp_pkg::FRAC_BITS);
    r = 128'(a) + prod;
    if (r > 128'(VMAX)) begin sat = 1; return VMAX; end
    if (r < 128'(VMIN)) begin sat = 1; return VMIN; end
    return 64'(r);
  endfunction

  task automatic predict_item(input trilerp_pkg::in_t it);
    logic signed [127:0] tx, ty, tz;
    logic signed [63:0]  c0, c1, c2, c3, r;
    bit   three, sat, ok;
    trilerp_pkg::out_t res;
    three = (dims_reg != trilerp_pkg::DIMS_2D);
    sat = 0;
    if (it.req_type == trilerp_pkg::REQ_LOAD) begin
      corners[it.corner_index] = 64'(it.corner_value);
      return;
    end
    ok = axis_frac(it.x_low, it.x_high, it.x_pos, tx);
    ok = ok && axis_frac(it.y_low, it.y_high, it.y_pos, ty);
    tz = '0;
    if (three) ok = ok && axis_frac(it.z_low, it.z_high, it.z_pos, tz);
    if (!ok) begin
      res.interp_value = '0;
      res.status = trilerp_pkg::ST_ZERO;
    end else begin
      if (three) begin
        c0 = blend(corners[0], corners[4], tx, sat);
        c1 = blend(corners[1], corners[5], tx, sat);
        c2 = blend(corners[2], corners[6], tx, sat);
        c3 = blend(corners[3], corners[7], tx, sat);
        c0 = blend(c0, c2, ty, sat);
        c1 = blend(c1, c3, ty, sat);
        r  = blend(c0, c1, tz, sat);
      end else begin
        c0 = blend(corners[0], corners[2], tx, sat);
        c1 = blend(corners[1], corners[3], tx, sat);
        r  = blend(c0, c1, ty, sat);
      end
      res.interp_value = r[31:0];
      res.status = sat ? trilerp_pkg::ST_SAT : trilerp_pkg::ST_OK;
    end
    expected_results.push_back(res);
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) predict_item(in_data_i);
    if (!(in_valid_i && !in_ready_o)) begin
      if (pending_items.size() != 0 && idle_gap == 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        idle_gap   <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
        if (idle_gap > 0) idle_gap <= idle_gap - 1;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_data_o.interp_value, out_data_o.status);
        n_errors++;
      end else begin
        trilerp_pkg::out_t e;
        e = expected_results.pop_front();
        if (out_data_o.interp_value !== e.interp_value) begin
          $display("%0t: interp_value expected %h actual %h", $time,
                   e.interp_value, out_data_o.interp_value);
          n_errors++;
        end
        if (out_data_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data_o.status);
          n_errors++;
        end
      end
    end
    if (stall_gap > 0) begin
      stall_gap   <= stall_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_gap <= gap_len();
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dims_reg = data[1:0];
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) << 16;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic trilerp_pkg::in_t mk_load(logic [2:0] idx, logic [31:0] v);
    trilerp_pkg::in_t it;
    it = trilerp_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = trilerp_pkg::REQ_LOAD;
    it.corner_index = idx;
    it.corner_value = v;
    return it;
  endfunction

  function automatic trilerp_pkg::in_t mk_query(int mode);
    trilerp_pkg::in_t it;
    logic signed [31:0] lo, w;
    it = trilerp_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = trilerp_pkg::REQ_QUERY;
    if (mode == 0) begin
      // well-formed cell, point inside
      lo = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      w  = 32'($urandom_range(1, 1 << 20));
      it.x_low = lo; it.x_high = lo + w; it.x_pos = lo + 32'($urandom_range(0, w));
      lo = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      w  = 32'($urandom_range(1, 1 << 20));
      it.y_low = lo + w; it.y_high = lo; it.y_pos = lo + 32'($urandom_range(0, w));
      lo = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      w  = 32'($urandom_range(1, 1 << 20));
      it.z_low = lo; it.z_high = lo + w; it.z_pos = lo + 32'($urandom_range(0, w));
    end else if (mode == 1) begin
      it.x_low = rand_val(); it.x_high = rand_val(); it.x_pos = rand_val();
      it.y_low = rand_val(); it.y_high = rand_val(); it.y_pos = rand_val();
      it.z_low = rand_val(); it.z_high = rand_val(); it.z_pos = rand_val();
    end else begin
      // zero-width axis on a random axis
      case ($urandom_range(0, 2))
        0: it.x_high = it.x_low;
        1: it.y_high = it.y_low;
        default: it.z_high = it.z_low;
      endcase
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 99);
      if (m < 35) pending_items.push_back(mk_load(3'($urandom), rand_val()));
      else if (m < 80) pending_items.push_back(mk_query(0));
      else if (m < 94) pending_items.push_back(mk_query(1));
      else pending_items.push_back(mk_query(2));
    end
  endtask

  initial begin
    trilerp_pkg::in_t it;
    dims_reg = trilerp_pkg::DIMS_RESET;
    foreach (corners[i]) corners[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: query on the cleared store, corner extremes, edges of the cell
    pending_items.push_back(mk_query(0));
    for (int i = 0; i < 8; i++)
      pending_items.push_back(mk_load(3'(i), (i % 2) ? 32'h7fff_ffff : 32'h8000_0000));
    it = mk_query(0);
    it.x_pos = it.x_high; it.y_pos = it.y_high; it.z_pos = it.z_low;
    pending_items.push_back(it);
    it = mk_query(0);
    it.x_low = 32'h8000_0000; it.x_high = 32'h7fff_ffff; it.x_pos = 32'h7fff_ffff;
    pending_items.push_back(it);
    it = mk_query(0);
    it.x_pos = it.x_high + 32'h0010_0000; // extrapolate past x_high
    pending_items.push_back(it);
    pending_items.push_back(mk_query(2));
    it = mk_query(0);
    it.x_high = it.x_low;
    it.y_high = 32'h7fff_ffff; it.y_low = 32'h8000_0000; it.y_pos = 32'h8000_0000;
    pending_items.push_back(it);
    for (int i = 0; i < 8; i++)
      pending_items.push_back(mk_load(3'(i), 32'(i) << 16));
    pending_items.push_back(mk_query(0));
    drain();

    // 2-D mode: z fields zero width must not matter
    apb_write(ADDR_DIMS, {30'd0, trilerp_pkg::DIMS_2D});
    it = mk_query(0);
    it.z_high = it.z_low;
    pending_items.push_back(it);
    random_phase(N_RANDOM / 4);
    drain();

    apb_write(ADDR_DIMS, 32'd0);
    random_phase(N_RANDOM / 4);
    drain();

    apb_write(ADDR_DIMS, 32'hffff_fffe);
    random_phase(N_RANDOM / 4);
    drain();

    apb_write(ADDR_DIMS, 32'd3);
    random_phase(N_RANDOM / 4);
    drain();

    if (n_errors == 0) $display("trilinear_interpolator_core regression: pass");
    else $display("trilinear_interpolator_core regression: fail");
    $finish;
  end

  initial begin
    #80ms;
    $display("trilinear_interpolator_core regression: fail");
    $finish;
  end

endmodule
